// ===== rtl/assert_macros.svh =====
// Assertion macros used by the frame receiver controller.
// Needs a clock named clk and a reset named rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PCFR_ASSERT(lbl, prop, msg)
`define PCFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/pcfr_pkg.sv =====
// Package of the parity and checksum frame receiver.
// Holds codes, register defaults and the types shared by controller and datapath.
package pcfr_pkg;

  localparam int MAX_FRAME_LEN_DEF = 32;

  localparam logic [1:0] PH_CODE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_REJ_CLR = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  localparam logic [1:0] CFG_ERROR_LIMIT = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_MIN_LEN     = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd3;

  localparam logic [3:0]  ERROR_LIMIT_RST = 4'd3;
  localparam logic [19:0] TIMEOUT_RST     = 20'd100;
  localparam logic [6:0]  MIN_LEN_RST     = 7'd1;
  localparam logic [6:0]  MAX_LEN_RST     = 7'd30;

  typedef enum logic [1:0] {
    OC_NONE,
    OC_REPLAY,
    OC_SINGLE
  } outcome_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic rd_next;
  } pcfr_cmd_t;

  typedef struct packed {
    outcome_t outcome;
    logic     last;
  } pcfr_sts_t;

endpackage

// ===== rtl/pcfr_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Standalone; used as the frame store.
module pcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pcfr_ctrl.sv =====
// Controller of the frame receiver: handshakes and replay sequencing.
// Depends on pcfr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pcfr_ctrl
  import pcfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pcfr_sts_t sts,
  output pcfr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IN,
    S_RD,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd.take    = 1'b0;
    cmd.rd_en   = 1'b0;
    cmd.rd_next = 1'b0;
    unique case (state)
      S_IN: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          priority case (sts.outcome)
            OC_REPLAY: state_next = S_RD;
            OC_SINGLE: state_next = S_OUT;
            default:   state_next = S_IN;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (sts.last) begin
            state_next = S_IN;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_stall  <= (state_next != S_IN);
      out_valid <= (state_next == S_OUT);
    end
  end

  `PCFR_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "Input taken while a word is shown")
  `PCFR_ASSERT(a_single_result,
    (in_valid && !in_stall && sts.outcome == OC_SINGLE) |=> (out_valid && sts.last),
    "Reject or timeout word not shown after its input")
  `PCFR_ASSERT(a_replay_continues,
    (out_valid && !out_stall && !sts.last) |=> (!out_valid && in_stall),
    "Replay did not continue with a store read")

endmodule

// ===== rtl/pcfr_datapath.sv =====
// Datapath of the frame receiver: frame checks, counters, registers and frame store.
// Depends on pcfr_pkg and pcfr_ram.
module pcfr_datapath
  import pcfr_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  pcfr_cmd_t   cmd,
  output pcfr_sts_t   sts,
  output logic [7:0]  out_byte,
  output logic [1:0]  status
);

  localparam int AW = $clog2(MAX_FRAME_LEN);
  localparam int CW = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [7:0] MAX_LEN8 = 8'(MAX_FRAME_LEN);

  logic [3:0]  error_limit;
  logic [19:0] timeout_ticks;
  logic [6:0]  min_length_field;
  logic [6:0]  max_length_field;

  logic [1:0]  phase, phase_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [6:0]  expected_length, expected_length_next;
  logic [7:0]  running_sum, running_sum_next;
  logic        header_ok, header_ok_next;
  logic [3:0]  rejects_counted, rejects_counted_next;
  logic [19:0] wait_timer, wait_timer_next;

  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] replay_len, replay_len_next;
  logic          use_ram;
  logic          last;

  outcome_t    outcome;
  logic [1:0]  res_status;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]  br_inc;
  logic [19:0] timer_inc;
  logic [19:0] timer_lim;
  logic [6:0]  len_field;
  logic        finish;
  logic        fin_good;
  logic        rd_last;
  logic [7:0]  ram_q;

  assign br_inc    = (bytes_received == 8'hFF) ? bytes_received : bytes_received + 8'd1;
  assign timer_inc = wait_timer + 20'd1;
  assign timer_lim = (timeout_ticks == 20'd0) ? 20'd1 : timeout_ticks;
  assign len_field = rx_byte[6:0];
  assign rd_last   = ((rd_cnt + CW'(1)) == replay_len);

  always_comb begin
    phase_next           = phase;
    bytes_received_next  = bytes_received;
    expected_length_next = expected_length;
    running_sum_next     = running_sum;
    header_ok_next       = header_ok;
    rejects_counted_next = rejects_counted;
    wait_timer_next      = wait_timer;
    replay_len_next      = replay_len;
    outcome              = OC_NONE;
    res_status           = ST_OK;
    wr_en                = 1'b0;
    wr_addr              = bytes_received[AW-1:0];
    finish               = 1'b0;
    fin_good             = 1'b0;

    if (action == ACT_TICK) begin
      if (phase == PH_LEN || phase == PH_DATA) begin
        wait_timer_next = timer_inc;
        if (timer_inc >= timer_lim) begin
          phase_next           = PH_CODE;
          bytes_received_next  = 8'd0;
          expected_length_next = 7'd0;
          running_sum_next     = 8'd0;
          header_ok_next       = 1'b0;
          wait_timer_next      = 20'd0;
          rejects_counted_next = 4'd0;
          outcome              = OC_SINGLE;
          res_status           = ST_TIMEOUT;
        end
      end
    end else begin
      priority case (phase)
        PH_LEN: begin
          wr_en                = (bytes_received < MAX_LEN8);
          bytes_received_next  = br_inc;
          expected_length_next = len_field;
          if ((^len_field) != rx_byte[7] || len_field < min_length_field ||
              len_field > max_length_field || ({1'b0, len_field} + 8'd2) > MAX_LEN8) begin
            header_ok_next = 1'b0;
          end
          running_sum_next = running_sum + {1'b0, len_field};
          if (len_field == 7'd0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en               = (bytes_received < MAX_LEN8);
          bytes_received_next = br_inc;
          if (br_inc >= ({1'b0, expected_length} + 8'd2)) begin
            finish   = 1'b1;
            fin_good = header_ok && (rx_byte == running_sum);
          end else begin
            running_sum_next = running_sum + rx_byte;
          end
        end
        default: begin
          wr_en                = 1'b1;
          wr_addr              = '0;
          bytes_received_next  = 8'd1;
          expected_length_next = 7'd0;
          running_sum_next     = {2'b00, rx_byte[5:0]};
          header_ok_next       = rx_byte[7] && ((^rx_byte[5:0]) == rx_byte[6]);
          wait_timer_next      = 20'd0;
          phase_next           = PH_LEN;
        end
      endcase

      if (finish) begin
        if (fin_good && br_inc <= MAX_LEN8) begin
          outcome         = OC_REPLAY;
          replay_len_next = br_inc[CW-1:0];
        end else begin
          outcome = OC_SINGLE;
          if (rejects_counted >= error_limit) begin
            rejects_counted_next = 4'd0;
            res_status           = ST_REJ_CLR;
          end else begin
            rejects_counted_next = rejects_counted + 4'd1;
            res_status           = ST_REJECT;
          end
        end
        phase_next           = PH_CODE;
        bytes_received_next  = 8'd0;
        expected_length_next = 7'd0;
        running_sum_next     = 8'd0;
        header_ok_next       = 1'b0;
        wait_timer_next      = 20'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit      <= ERROR_LIMIT_RST;
      timeout_ticks    <= TIMEOUT_RST;
      min_length_field <= MIN_LEN_RST;
      max_length_field <= MAX_LEN_RST;
      phase            <= PH_CODE;
      bytes_received   <= 8'd0;
      expected_length  <= 7'd0;
      running_sum      <= 8'd0;
      header_ok        <= 1'b0;
      rejects_counted  <= 4'd0;
      wait_timer       <= 20'd0;
      last             <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ERROR_LIMIT: error_limit      <= cfg_wdata[3:0];
          CFG_TIMEOUT:     timeout_ticks    <= cfg_wdata;
          CFG_MIN_LEN:     min_length_field <= cfg_wdata[6:0];
          CFG_MAX_LEN:     max_length_field <= cfg_wdata[6:0];
        endcase
      end
      if (cmd.take) begin
        phase           <= phase_next;
        bytes_received  <= bytes_received_next;
        expected_length <= expected_length_next;
        running_sum     <= running_sum_next;
        header_ok       <= header_ok_next;
        rejects_counted <= rejects_counted_next;
        wait_timer      <= wait_timer_next;
        if (outcome == OC_SINGLE) begin
          last <= 1'b1;
        end
      end
      if (cmd.rd_en) begin
        last <= rd_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && outcome == OC_SINGLE) begin
      use_ram <= 1'b0;
      status  <= res_status;
    end else if (cmd.take && outcome == OC_REPLAY) begin
      use_ram    <= 1'b1;
      status     <= ST_OK;
      rd_cnt     <= '0;
      replay_len <= replay_len_next;
    end else if (cmd.rd_next) begin
      rd_cnt <= rd_cnt + CW'(1);
    end
  end

  pcfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_LEN)
  ) u_store (
    .clk  (clk),
    .we   (cmd.take && action == ACT_BYTE && wr_en),
    .waddr(wr_addr),
    .wdata(rx_byte),
    .re   (cmd.rd_en),
    .raddr(rd_cnt[AW-1:0]),
    .rdata(ram_q)
  );

  assign out_byte    = use_ram ? ram_q : 8'd0;
  assign sts.outcome = outcome;
  assign sts.last    = last;

endmodule

// ===== rtl/parity_checksum_frame_receiver_top.sv =====
// A word that completes no frame is taken without raising in_stall; a reject or timeout
// word is shown the cycle after its input, and a good frame is replayed word by word
// (frame store read, then output word), beginning with a store read after the input.
// Throughput: one input word per cycle between frames; the controller alternates a store
// read and an output word, which sets the replay pace. Synchronous active-high reset
// clears the control state and loads the register defaults; the frame store is not cleared.
module parity_checksum_frame_receiver_top
  import pcfr_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic        last
);

  pcfr_cmd_t cmd;
  pcfr_sts_t sts;

  pcfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcfr_datapath #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .action   (action),
    .rx_byte  (rx_byte),
    .cmd      (cmd),
    .sts      (sts),
    .out_byte (out_byte),
    .status   (status)
  );

  assign last = sts.last;

endmodule
